// ----- rtl/mm3_pkg.sv -----
// Shared constants and types for the MurmurHash3 x86_32 stream hasher.
// No dependencies; imported by every module under rtl/.
package mm3_pkg;

    localparam logic [31:0] MM3_C1  = 32'hcc9e2d51;
    localparam logic [31:0] MM3_C2  = 32'h1b873593;
    localparam logic [31:0] MM3_ADD = 32'he6546b64;
    localparam logic [31:0] MM3_F1  = 32'h85ebca6b;
    localparam logic [31:0] MM3_F2  = 32'hc2b2ae35;

    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [2:0] BYTES_NONE  = 3'd0;
    localparam logic [2:0] BYTES_ONE   = 3'd1;
    localparam logic [2:0] BYTES_TWO   = 3'd2;
    localparam logic [2:0] BYTES_THREE = 3'd3;
    localparam logic [2:0] BYTES_FULL  = 3'd4;

    localparam int S_TDATA_W = 40;

    // One classified item on its way from the front to the back.
    typedef struct packed {
        logic [31:0] word;       // masked message bytes
        logic [2:0]  add_count;  // bytes this item adds to the length
        logic        fold;       // full word: rotate and multiply-add after XOR
        logic        last;       // finalize and emit after this item
    } mm3_item_t;

    typedef struct packed {
        logic      push;
        mm3_item_t item;
    } mm3_push_t;

    typedef struct packed {
        logic full;
        logic empty;
    } mm3_qstat_t;

    typedef struct packed {
        logic busy;
        logic open;
    } mm3_bstat_t;

endpackage

// ----- rtl/mm3_queue.sv -----
// Short item queue between the front and the back of the hasher.
// Depends on mm3_pkg.
module mm3_queue
    import mm3_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  mm3_push_t  push,
    input  logic       pop,
    output mm3_item_t  head,
    output mm3_qstat_t stat
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    mm3_item_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               do_push, do_pop;

    assign stat.full  = (count_reg == CNT_W'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign do_push    = push.push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign head       = entries_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push.item;
        end
    end

endmodule

// ----- rtl/mm3_front.sv -----
// Input side of the hasher: accept items, mask tails, classify into queue entries.
// Depends on mm3_pkg.
module mm3_front
    import mm3_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] data_word, [34:32] byte_count
    input  logic                 s_tlast,
    input  mm3_qstat_t           q_stat,
    output mm3_push_t            push
);

    logic [31:0] word;
    logic [2:0]  count;
    logic [2:0]  count_sat;
    logic [31:0] mask;

    assign word  = s_tdata[31:0];
    assign count = s_tdata[34:32];

    assign s_tready = !q_stat.full;

    always_comb begin
        push.push = s_tvalid && !q_stat.full;
        count_sat = (count > BYTES_FULL) ? BYTES_FULL : count;
        case (count_sat)
            BYTES_NONE:  mask = 32'h0000_0000;
            BYTES_ONE:   mask = 32'h0000_00ff;
            BYTES_TWO:   mask = 32'h0000_ffff;
            BYTES_THREE: mask = 32'h00ff_ffff;
            default:     mask = 32'hffff_ffff;
        endcase

        push.item.last = s_tlast;
        if (!s_tlast) begin
            // Count is ignored before the last item: always a full word.
            push.item.word      = word;
            push.item.add_count = BYTES_FULL;
            push.item.fold      = 1'b1;
        end else begin
            push.item.word      = word & mask;
            push.item.add_count = count_sat;
            push.item.fold      = (count_sat == BYTES_FULL);
        end
    end

endmodule

// ----- rtl/mm3_back.sv -----
// Hash engine: scramble, fold, finalize, and the output register.
// Depends on mm3_pkg; one shared 32x32 multiplier, stepped by a small sequencer.
module mm3_back
    import mm3_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [31:0] seed,
    input  mm3_item_t   q_head,
    input  mm3_qstat_t  q_stat,
    output logic        q_pop,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,
    output mm3_bstat_t  b_stat
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_K1   = 3'd1;
    localparam logic [2:0] ST_K2   = 3'd2;
    localparam logic [2:0] ST_FOLD = 3'd3;
    localparam logic [2:0] ST_F1   = 3'd4;
    localparam logic [2:0] ST_F2   = 3'd5;
    localparam logic [2:0] ST_OUT  = 3'd6;

    logic [2:0]  state_reg, state_next;
    mm3_item_t   item_reg, item_next;
    logic [31:0] h_reg, h_next;
    logic [31:0] total_reg, total_next;
    logic [31:0] k_reg, k_next;
    logic        open_reg, open_next;
    logic        m_valid_reg, m_valid_next;
    logic [31:0] m_data_reg, m_data_next;

    logic [31:0] mul_a, mul_b, mul_p;
    logic [31:0] hx, hr, hf;

    assign m_tvalid    = m_valid_reg;
    assign m_tdata     = m_data_reg;
    assign b_stat.busy = (state_reg != ST_IDLE);
    assign b_stat.open = open_reg;

    // Operand select for the shared multiplier.
    always_comb begin
        case (state_reg)
            ST_K2: begin
                mul_a = {k_reg[16:0], k_reg[31:17]};
                mul_b = MM3_C2;
            end
            ST_F1: begin
                mul_a = h_reg ^ {16'd0, h_reg[31:16]};
                mul_b = MM3_F1;
            end
            ST_F2: begin
                mul_a = h_reg ^ {13'd0, h_reg[31:13]};
                mul_b = MM3_F2;
            end
            default: begin
                mul_a = item_reg.word;
                mul_b = MM3_C1;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Fold step: XOR in the scrambled word, then rotate and multiply-add for a full word.
    assign hx = h_reg ^ k_reg;
    assign hr = {hx[18:0], hx[31:19]};
    assign hf = item_reg.fold ? ({hr[29:0], 2'b00} + hr + MM3_ADD) : hx;

    always_comb begin
        state_next   = state_reg;
        item_next    = item_reg;
        h_next       = h_reg;
        total_next   = total_reg;
        k_next       = k_reg;
        open_next    = open_reg;
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_tready;
        q_pop        = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (!q_stat.empty) begin
                    q_pop     = 1'b1;
                    item_next = q_head;
                    open_next = 1'b1;
                    if (open_reg) begin
                        total_next = total_reg + {29'd0, q_head.add_count};
                    end else begin
                        // Start of a message: load the seed, restart the length.
                        h_next     = seed;
                        total_next = {29'd0, q_head.add_count};
                    end
                    state_next = ST_K1;
                end
            end
            ST_K1: begin
                k_next     = mul_p;
                state_next = ST_K2;
            end
            ST_K2: begin
                k_next     = mul_p;
                state_next = ST_FOLD;
            end
            ST_FOLD: begin
                if (item_reg.last) begin
                    h_next     = hf ^ total_reg;
                    open_next  = 1'b0;
                    state_next = ST_F1;
                end else begin
                    h_next     = hf;
                    state_next = ST_IDLE;
                end
            end
            ST_F1: begin
                h_next     = mul_p;
                state_next = ST_F2;
            end
            ST_F2: begin
                h_next     = mul_p;
                state_next = ST_OUT;
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_data_next  = h_reg ^ {16'd0, h_reg[31:16]};
                    m_valid_next = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            open_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
            h_reg       <= '0;
            total_reg   <= '0;
        end else begin
            state_reg   <= state_next;
            open_reg    <= open_next;
            m_valid_reg <= m_valid_next;
            h_reg       <= h_next;
            total_reg   <= total_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg   <= item_next;
        k_reg      <= k_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ----- rtl/murmur3_32_stream_hash.sv -----
// Top level of the streaming MurmurHash3 x86_32 hasher.
// Depends on mm3_pkg, mm3_front, mm3_queue and mm3_back.
//
// Feed a message as little-endian 32-bit words on the s_ stream; mark the final
// word with s_tlast and give its valid byte count (0 to 4, larger values count
// as 4) in s_tdata[34:32]. Words before the last always count as four bytes. One
// 32-bit hash per message comes out on the m_ stream. Write the seed through
// cfg_we/cfg_wdata while the block is idle; it is loaded at the start of each
// message. The front accepts an item in any cycle the queue (QUEUE_DEPTH items)
// has room, so bursts up to that depth go in at one item per cycle. The back
// engine shares one 32x32 multiplier across both scramble multiplies and both
// finalizer multiplies, so it steps through pop, two scramble multiplies and
// fold for each non-last item, adding the two finalizer multiplies and the
// output load for a last item, and waits if the result register is still held
// by a stalled m_ side. It pops no new item until the current one is done.
module murmur3_32_stream_hash
    import mm3_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Seed register write port
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    // Message words in
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] data_word, [34:32] byte_count
    input  logic                 s_tlast,   // last
    // Hash out
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata    // [31:0] hash_value
);

    logic [31:0] seed_reg, seed_next;
    mm3_push_t   q_push;
    mm3_qstat_t  q_stat;
    mm3_item_t   q_head;
    logic        q_pop;
    mm3_bstat_t  b_stat;

    // Hold the seed until rewritten.
    assign seed_next = cfg_we ? cfg_wdata : seed_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= '0;
        end else begin
            seed_reg <= seed_next;
        end
    end

    mm3_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .q_stat   (q_stat),
        .push     (q_push)
    );

    mm3_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (q_push),
        .pop     (q_pop),
        .head    (q_head),
        .stat    (q_stat)
    );

    mm3_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .seed     (seed_reg),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .b_stat   (b_stat)
    );

    // An item taken while everything is empty must reach the queue or the engine.
    a_item_not_lost: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && q_stat.empty && !b_stat.busy)
            |=> (b_stat.busy || !q_stat.empty))
        else $error("accepted item vanished");

    // A new result appears only after the message has been closed.
    a_result_closes_msg: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid) |-> !b_stat.open)
        else $error("result emitted with message still open");

    // Reset empties the queue, idles the engine and drops any result.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!m_tvalid && q_stat.empty && !b_stat.busy && !b_stat.open))
        else $error("state not cleared by reset");

endmodule

// ----- sim/mm3_stream_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for murmur3_32_stream_hash: watches the seed port and both streams,
// predicts each message hash and compares it with what comes out.
// Depends on mm3_pkg for the byte-count codes and the input item width.
module mm3_stream_checker
    import mm3_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [31:0]          cfg_wdata,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,   // [31:0] data_word, [34:32] byte_count
    input  logic                 s_tlast,   // last
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [31:0]          m_tdata,   // [31:0] hash_value
    output int                   mismatch_count,
    output int                   hashes_pending
);

    localparam logic [31:0] KEY_MUL1 = 32'hcc9e2d51;
    localparam logic [31:0] KEY_MUL2 = 32'h1b873593;
    localparam logic [31:0] FOLD_ADD = 32'he6546b64;
    localparam logic [31:0] FIN_MUL1 = 32'h85ebca6b;
    localparam logic [31:0] FIN_MUL2 = 32'hc2b2ae35;

    logic [31:0] seed_q;
    logic [31:0] run_hash;
    logic [31:0] run_len;
    logic        msg_open;
    logic [31:0] pending_hashes[$];

    function automatic logic [31:0] rotl(input logic [31:0] v, input int sh);
        return (v << sh) | (v >> (32 - sh));
    endfunction

    function automatic logic [31:0] key_scramble(input logic [31:0] k);
        logic [31:0] t;
        t = k * KEY_MUL1;
        t = rotl(t, 15);
        t = t * KEY_MUL2;
        return t;
    endfunction

    function automatic logic [31:0] fold_word(input logic [31:0] h, input logic [31:0] k);
        logic [31:0] t;
        t = rotl(h ^ key_scramble(k), 13);
        return t * 32'd5 + FOLD_ADD;
    endfunction

    function automatic logic [31:0] avalanche(input logic [31:0] h);
        logic [31:0] t;
        t = h ^ (h >> 16);
        t = t * FIN_MUL1;
        t = t ^ (t >> 13);
        t = t * FIN_MUL2;
        t = t ^ (t >> 16);
        return t;
    endfunction

    // Advance the running hash by one item; a last item queues the finished hash.
    task automatic absorb_item(input logic [31:0] word, input logic [2:0] count,
                               input logic is_last);
        logic [2:0]  nbytes;
        logic [31:0] mask;
        if (!msg_open) begin
            run_hash = seed_q;
            run_len  = '0;
            msg_open = 1'b1;
        end
        if (!is_last) begin
            run_hash = fold_word(run_hash, word);
            run_len  = run_len + 32'd4;
        end else begin
            nbytes = (count > BYTES_FULL) ? BYTES_FULL : count;
            if (nbytes == BYTES_FULL) begin
                run_hash = fold_word(run_hash, word);
            end else if (nbytes != BYTES_NONE) begin
                mask     = 32'hffffffff >> (32 - 8 * int'(nbytes));
                run_hash = run_hash ^ key_scramble(word & mask);
            end
            run_len = run_len + 32'(nbytes);
            pending_hashes.push_back(avalanche(run_hash ^ run_len));
            msg_open = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            seed_q   = '0;
            run_hash = '0;
            run_len  = '0;
            msg_open = 1'b0;
            pending_hashes.delete();
            mismatch_count <= 0;
        end else begin
            if (cfg_we)
                seed_q = cfg_wdata;
            if (s_tvalid && s_tready)
                absorb_item(s_tdata[31:0], s_tdata[34:32], s_tlast);
            if (m_tvalid && m_tready) begin
                if (pending_hashes.size() == 0) begin
                    $display("%0t: hash %08h with none expected", $time, m_tdata);
                    mismatch_count <= mismatch_count + 1;
                end else if (pending_hashes[0] !== m_tdata) begin
                    $display("%0t: hash mismatch, expected %08h, got %08h",
                             $time, pending_hashes[0], m_tdata);
                    mismatch_count <= mismatch_count + 1;
                    void'(pending_hashes.pop_front());
                end else begin
                    void'(pending_hashes.pop_front());
                end
            end
        end
        hashes_pending <= pending_hashes.size();
    end

endmodule

// ----- sim/murmur3_32_stream_hash_test.sv -----
`timescale 1ns / 100ps
// Top of the murmur3_32_stream_hash testbench: clock, reset, seed writes and
// message stimulus under several traffic patterns, watchdog and verdict.
// Depends on mm3_pkg, murmur3_32_stream_hash and mm3_stream_checker.
module murmur3_32_stream_hash_test
    import mm3_pkg::*;
();

    // Stop if nothing moves on either stream for this many cycles.
    localparam int WATCHDOG_LIMIT = 4000;
    // Cycles to let the block settle before a seed write and at the end.
    localparam int SETTLE_CYCLES  = 64;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 212;

    typedef enum int {
        TRAFFIC_STEADY,
        TRAFFIC_SENDER_GAPS,
        TRAFFIC_SINK_STALLS,
        TRAFFIC_BOTH
    } traffic_mode_t;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [31:0]          cfg_wdata = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata   = '0;   // [31:0] data_word, [34:32] byte_count
    logic                 s_tlast   = 1'b0; // last
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [31:0]          m_tdata;          // [31:0] hash_value

    int mismatch_count;
    int hashes_pending;
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int stall_cycles   = 0;
    int phase_items;

    always #1 aclk = ~aclk;

    murmur3_32_stream_hash u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    mm3_stream_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .s_tlast        (s_tlast),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .mismatch_count (mismatch_count),
        .hashes_pending (hashes_pending)
    );

    // Sink side: drop tready at random according to the current stall rate.
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Watchdog: count cycles in which no item moves on either stream.
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("murmur3_32_stream_hash verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    task automatic set_traffic(input traffic_mode_t mode);
        case (mode)
            TRAFFIC_STEADY: begin
                send_idle_pct  = 0;
                recv_stall_pct = 0;
            end
            TRAFFIC_SENDER_GAPS: begin
                send_idle_pct  = 70;
                recv_stall_pct = 0;
            end
            TRAFFIC_SINK_STALLS: begin
                send_idle_pct  = 0;
                recv_stall_pct = 70;
            end
            default: begin
                send_idle_pct  = 28;
                recv_stall_pct = 28;
            end
        endcase
    endtask

    // Present one item and hold it until accepted. Call at a rising edge;
    // returns at the edge that took the item.
    task automatic send_item(input logic [31:0] word, input logic [2:0] count,
                             input logic is_last);
        if ($urandom_range(99) < send_idle_pct) begin
            // Drop tvalid for a random gap before the next item.
            s_tvalid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(S_TDATA_W - 35){1'b0}}, count, word};
        s_tlast  <= is_last;
        // Sample tready mid-cycle, where it is stable, then advance to the edge.
        @(negedge aclk);
        while (!s_tready)
            @(negedge aclk);
        @(posedge aclk);
        phase_items++;
    endtask

    // Data words lean toward all-zeros and all-ones now and then.
    function automatic logic [31:0] pick_word();
        case ($urandom_range(15))
            0:       return 32'h00000000;
            1:       return 32'hffffffff;
            default: return $urandom;
        endcase
    endfunction

    // One message: random body words with junk counts, then a last item
    // whose count spans 0 to 7 so tails and saturation both come up.
    task automatic send_message();
        int unsigned body_words;
        body_words = ($urandom_range(8) == 0) ? $urandom_range(40) : $urandom_range(6);
        for (int unsigned i = 0; i < body_words; i++)
            send_item(pick_word(), 3'($urandom_range(7)), 1'b0);
        send_item(pick_word(), 3'($urandom_range(7)), 1'b1);
    endtask

    // Hold until every expected hash is back, then let the engine settle.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (hashes_pending != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_seed(input logic [31:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    initial begin
        logic [31:0] seed;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed part under the reset seed, no idling.
        set_traffic(TRAFFIC_STEADY);
        phase_items = 0;
        // Empty message; the data bits must be ignored.
        send_item(32'hffffffff, BYTES_NONE, 1'b1);
        // Single-item tails of one, two and three bytes with junk above.
        send_item(32'hffffffff, BYTES_ONE, 1'b1);
        send_item(32'h12345678, BYTES_TWO, 1'b1);
        send_item(32'hffffffff, BYTES_THREE, 1'b1);
        // Full last word, then counts above four that saturate.
        send_item(32'hffffffff, BYTES_FULL, 1'b1);
        send_item(32'h00000000, 3'd7, 1'b1);
        send_item(32'hdeadbeef, 3'd5, 1'b1);
        send_item(32'h80000001, 3'd6, 1'b1);
        // Multi-word messages; counts on body words must be ignored.
        send_item(32'h00000000, BYTES_NONE, 1'b0);
        send_item(32'hffffffff, 3'd7, 1'b0);
        send_item(32'ha5a5a5a5, BYTES_THREE, 1'b0);
        send_item(32'h5a5a5a5a, BYTES_NONE, 1'b1);
        send_item(32'hffffffff, 3'd5, 1'b0);
        send_item(32'h00000000, BYTES_THREE, 1'b1);
        send_item(32'h00000000, BYTES_FULL, 1'b0);
        send_item(32'h80000001, BYTES_ONE, 1'b0);
        send_item(32'hffffffff, BYTES_FULL, 1'b1);
        drain();

        // Random phases: new seed each time, cycling through traffic patterns.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0:       seed = 32'hffffffff;
                1:       seed = 32'h00000000;
                3:       seed = 32'h00000001;
                5:       seed = 32'h80000000;
                default: seed = $urandom;
            endcase
            write_seed(seed);
            set_traffic(traffic_mode_t'(phase % 4));
            phase_items = 0;
            while (phase_items < PHASE_ITEMS)
                send_message();
            drain();
        end

        if (mismatch_count == 0 && hashes_pending == 0) begin
            $display("murmur3_32_stream_hash verification clean");
        end else begin
            if (hashes_pending != 0)
                $display("%0t: %0d hashes never arrived", $time, hashes_pending);
            $display("murmur3_32_stream_hash verification failed");
        end
        $finish;
    end

endmodule
